[sv/agg_pkg.sv]
`default_nettype none
package agg_pkg;

  // grid and table sizes
  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 128;
  localparam int MAX_SEEDS   = 255;

  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int SIW   = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNW   = $clog2(MAX_SEEDS + 1);
  localparam int LW    = 8;
  localparam int RW    = 9;
  localparam int TW    = 17;
  localparam int DMW   = (XW > YW) ? XW : YW;
  localparam int DW    = DMW + 8;
  localparam int DCW   = $clog2(DW);

  localparam logic [RW-1:0] MAX_ROUNDS_RST = RW'(300);

  // item modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] pos_x;
    logic [6:0] pos_y;
    logic [7:0] speed_x_minus;
    logic [7:0] speed_y_minus;
    logic [7:0] speed_x_plus;
    logic [7:0] speed_y_plus;
    logic [7:0] birth_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_label;
    logic       run_done;
  } out_item_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [7:0]    sxm;
    logic [7:0]    sym;
    logic [7:0]    sxp;
    logic [7:0]    syp;
    logic [7:0]    birth;
  } seed_t;

  typedef struct packed {
    logic [LW-1:0] owner;
    logic [RW-1:0] stamp;
  } cell_t;

  // which label the seed table read serves
  typedef enum logic [1:0] {
    SRC_PLANT = 2'd0,
    SRC_OTHER = 2'd1,
    SRC_ME    = 2'd2
  } src_t;

  typedef struct packed {
    logic item_ld;
    logic seed_clr;
    logic seed_app;
    logic clr_start;
    logic clr_step;
    logic idx_init;
    logic seed_rd;
    src_t seed_src;
    logic plant;
    logic round_init;
    logic round_next;
    logic cell_rd;
    logic me_ld;
    logic cell_next;
    logic k_init;
    logic k_next;
    logic nb_rd;
    logic claim;
    logic arr_start;
    logic t_oth_ld;
    logic rd_pos;
    logic out_read;
    logic out_run;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic seed_end;
    logic rounds_zero;
    logic cell_claim;
    logic cell_last;
    logic round_last;
    logic k_last;
    logic nb_in;
    logic nb_empty;
    logic nb_foreign;
    logic arr_done;
    logic arr_win;
  } status_t;

  // neighbour offsets in claim order
  function automatic logic signed [1:0] nbr_dx(input logic [2:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0: d = -2'sd1;
      3'd1: d = 2'sd0;
      3'd2: d = -2'sd1;
      3'd3: d = 2'sd1;
      3'd4: d = 2'sd1;
      3'd5: d = 2'sd0;
      3'd6: d = 2'sd1;
      3'd7: d = -2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nbr_dy(input logic [2:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0: d = -2'sd1;
      3'd1: d = -2'sd1;
      3'd2: d = 2'sd0;
      3'd3: d = 2'sd1;
      3'd4: d = 2'sd0;
      3'd5: d = 2'sd1;
      3'd6: d = -2'sd1;
      3'd7: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(AW'(x) * AW'(GRID_HEIGHT) + AW'(y));
  endfunction

endpackage
`default_nettype wire

[sv/agg_arr.sv]
`default_nettype none
module agg_arr (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire agg_pkg::seed_t        seed,
  input  wire logic [agg_pkg::XW-1:0] nx,
  input  wire logic [agg_pkg::YW-1:0] ny,
  output logic                       done,
  output logic [agg_pkg::TW-1:0]     arr_time
);

  typedef enum logic [6:0] {
    A_IDLE = 7'b0000001,
    A_DIVX = 7'b0000010,
    A_DIVY = 7'b0000100,
    A_SQX  = 7'b0001000,
    A_SQY  = 7'b0010000,
    A_SQRT = 7'b0100000,
    A_FIN  = 7'b1000000
  } arr_state_t;

  arr_state_t                 state_r, state_nxt;
  logic [agg_pkg::XW-1:0]     magx_r;
  logic [agg_pkg::YW-1:0]     magy_r;
  logic [7:0]                 spx_r, spy_r, birth_r;
  logic [agg_pkg::DW-1:0]     num_r, quo_r;
  logic [7:0]                 rem_r;
  logic [agg_pkg::DCW-1:0]    dcnt_r;
  logic [15:0]                qx_r, qy_r;
  logic [31:0]                sq_r;
  logic [32:0]                v_r, res_r, sbit_r;
  logic [4:0]                 scnt_r;
  logic                       done_r;
  logic [agg_pkg::TW-1:0]     time_r;

  logic signed [agg_pkg::XW:0] dxs;
  logic signed [agg_pkg::YW:0] dys;
  logic [agg_pkg::DMW-1:0]    cur_mag;
  logic [7:0]                 cur_d;
  logic [8:0]                 trial;
  logic                       ge;
  logic [agg_pkg::DW-1:0]     quo_fin;
  logic [15:0]                q_sat;
  logic [33:0]                sq_sum;
  logic                       sq_ge;

  // signed offsets from the seed
  assign dxs = $signed({1'b0, nx}) - $signed({1'b0, seed.x});
  assign dys = $signed({1'b0, ny}) - $signed({1'b0, seed.y});

  // restoring divider, one quotient bit a cycle
  assign cur_mag = (state_r == A_DIVX) ? agg_pkg::DMW'(magx_r) : agg_pkg::DMW'(magy_r);
  assign cur_d   = (state_r == A_DIVX) ? spx_r : spy_r;
  assign trial   = {rem_r, num_r[agg_pkg::DW-1]};
  assign ge      = (trial >= {1'b0, cur_d});
  assign quo_fin = {quo_r[agg_pkg::DW-2:0], ge};

  always_comb begin
    if (cur_mag == '0) begin
      q_sat = 16'd0;
    end else if (cur_d == 8'd0) begin
      q_sat = 16'hFFFF;
    end else if (quo_fin > agg_pkg::DW'(16'hFFFF)) begin
      q_sat = 16'hFFFF;
    end else begin
      q_sat = 16'(quo_fin);
    end
  end

  // square root step
  assign sq_sum = 34'(res_r) + 34'(sbit_r);
  assign sq_ge  = (34'(v_r) >= sq_sum);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE: if (start) state_nxt = A_DIVX;
      A_DIVX: if (dcnt_r == '0) state_nxt = A_DIVY;
      A_DIVY: if (dcnt_r == '0) state_nxt = A_SQX;
      A_SQX:  state_nxt = A_SQY;
      A_SQY:  state_nxt = A_SQRT;
      A_SQRT: if (scnt_r == 5'd0) state_nxt = A_FIN;
      A_FIN:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == A_FIN);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        if (start) begin
          magx_r  <= agg_pkg::XW'((dxs < 0) ? -dxs : dxs);
          magy_r  <= agg_pkg::YW'((dys < 0) ? -dys : dys);
          spx_r   <= (dxs > 0) ? seed.sxp : seed.sxm;
          spy_r   <= (dys > 0) ? seed.syp : seed.sym;
          birth_r <= seed.birth;
          num_r   <= agg_pkg::DW'((agg_pkg::DW'(agg_pkg::XW'((dxs < 0) ? -dxs : dxs))) << 8);
          rem_r   <= 8'd0;
          quo_r   <= '0;
          dcnt_r  <= agg_pkg::DCW'(agg_pkg::DW - 1);
        end
      end
      A_DIVX, A_DIVY: begin
        if ((dcnt_r == '0) && (state_r == A_DIVX)) begin
          // x quotient done, load the y division
          qx_r   <= q_sat;
          num_r  <= agg_pkg::DW'(agg_pkg::DW'(magy_r) << 8);
          rem_r  <= 8'd0;
          quo_r  <= '0;
          dcnt_r <= agg_pkg::DCW'(agg_pkg::DW - 1);
        end else begin
          rem_r  <= ge ? 8'(trial - {1'b0, cur_d}) : 8'(trial);
          num_r  <= {num_r[agg_pkg::DW-2:0], 1'b0};
          quo_r  <= quo_fin;
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == '0) qy_r <= q_sat;
        end
      end
      A_SQX: begin
        sq_r <= qx_r * qx_r;
      end
      A_SQY: begin
        v_r    <= 33'(sq_r) + 33'(qy_r * qy_r);
        res_r  <= '0;
        sbit_r <= 33'(1) << 32;
        scnt_r <= 5'd16;
      end
      A_SQRT: begin
        if (sq_ge) begin
          v_r   <= 33'(34'(v_r) - sq_sum);
          res_r <= (res_r >> 1) + sbit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
        scnt_r <= scnt_r - 1'b1;
      end
      A_FIN: begin
        time_r <= agg_pkg::TW'((res_r > 33'd65535) ? 16'hFFFF : 16'(res_r))
                  + agg_pkg::TW'({birth_r, 8'd0});
      end
      default: begin
      end
    endcase
  end

  assign done     = done_r;
  assign arr_time = time_r;

endmodule
`default_nettype wire

[sv/agg_dp.sv]
`default_nettype none
module agg_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire agg_pkg::in_item_t   in_item,
  input  wire logic                cfg_we,
  input  wire logic [8:0]          cfg_wdata,
  input  wire agg_pkg::cmd_t       cmd,
  output agg_pkg::status_t         st,
  output logic                     out_valid,
  output agg_pkg::out_item_t       out_item
);

  agg_pkg::seed_t             seed_mem [agg_pkg::MAX_SEEDS];
  agg_pkg::cell_t             cell_mem [agg_pkg::CELLS];

  logic [agg_pkg::CNW-1:0]    seed_count_r, seed_idx_r;
  logic [agg_pkg::RW-1:0]     max_rounds_r, round_r;
  logic [agg_pkg::AW-1:0]     clr_addr_r;
  logic [agg_pkg::XW-1:0]     x_r, nx_r;
  logic [agg_pkg::YW-1:0]     y_r, ny_r;
  logic [2:0]                 k_r;
  logic [agg_pkg::LW-1:0]     me_r;
  agg_pkg::seed_t             seed_rd_r;
  agg_pkg::cell_t             cell_rd_r;
  agg_pkg::in_item_t          item_r;
  logic [agg_pkg::TW-1:0]     t_oth_r;
  logic                       out_valid_r;
  agg_pkg::out_item_t         out_r;

  logic signed [agg_pkg::XW+1:0] nxs;
  logic signed [agg_pkg::YW+1:0] nys;
  logic [agg_pkg::AW-1:0]     cell_raddr, cell_waddr;
  agg_pkg::cell_t             cell_wdata;
  logic                       cell_we, cell_re;
  logic [agg_pkg::SIW-1:0]    seed_raddr;
  logic                       item_in_grid;
  logic                       arr_done;
  logic [agg_pkg::TW-1:0]     arr_time;

  // neighbour coordinates and range check
  assign nxs = $signed({2'b0, x_r}) + (agg_pkg::XW+2)'(agg_pkg::nbr_dx(k_r));
  assign nys = $signed({2'b0, y_r}) + (agg_pkg::YW+2)'(agg_pkg::nbr_dy(k_r));

  assign item_in_grid = (int'(item_r.pos_x) < agg_pkg::GRID_WIDTH) &&
                        (int'(item_r.pos_y) < agg_pkg::GRID_HEIGHT);

  // cell memory port selection
  always_comb begin
    cell_re    = cmd.cell_rd | cmd.nb_rd | cmd.rd_pos;
    cell_raddr = agg_pkg::cell_addr(x_r, y_r);
    if (cmd.rd_pos) begin
      cell_raddr = agg_pkg::cell_addr(agg_pkg::XW'(item_r.pos_x), agg_pkg::YW'(item_r.pos_y));
    end else if (cmd.nb_rd) begin
      cell_raddr = agg_pkg::cell_addr(agg_pkg::XW'(nxs), agg_pkg::YW'(nys));
    end
    cell_we    = cmd.clr_step | cmd.plant | cmd.claim;
    cell_waddr = clr_addr_r;
    cell_wdata = '0;
    if (cmd.plant) begin
      cell_waddr = agg_pkg::cell_addr(seed_rd_r.x, seed_rd_r.y);
      cell_wdata = '{owner: agg_pkg::LW'(seed_idx_r + 1'b1), stamp: '0};
    end else if (cmd.claim) begin
      cell_waddr = agg_pkg::cell_addr(nx_r, ny_r);
      cell_wdata = '{owner: me_r, stamp: round_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    if (cell_re) cell_rd_r <= cell_mem[cell_raddr];
  end

  // seed table
  always_comb begin
    case (cmd.seed_src)
      agg_pkg::SRC_OTHER: seed_raddr = agg_pkg::SIW'(cell_rd_r.owner - 1'b1);
      agg_pkg::SRC_ME:    seed_raddr = agg_pkg::SIW'(me_r - 1'b1);
      default:            seed_raddr = agg_pkg::SIW'(seed_idx_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_app && (int'(seed_count_r) < agg_pkg::MAX_SEEDS)) begin
      seed_mem[agg_pkg::SIW'(seed_count_r)] <= '{
        x:     agg_pkg::XW'(in_item.pos_x % agg_pkg::GRID_WIDTH),
        y:     agg_pkg::YW'(in_item.pos_y % agg_pkg::GRID_HEIGHT),
        sxm:   in_item.speed_x_minus,
        sym:   in_item.speed_y_minus,
        sxp:   in_item.speed_x_plus,
        syp:   in_item.speed_y_plus,
        birth: in_item.birth_time
      };
    end
    if (cmd.seed_rd) seed_rd_r <= seed_mem[seed_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_count_r <= '0;
      max_rounds_r <= agg_pkg::MAX_ROUNDS_RST;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) max_rounds_r <= cfg_wdata;
      if (cmd.seed_clr) begin
        seed_count_r <= '0;
      end else if (cmd.seed_app && (int'(seed_count_r) < agg_pkg::MAX_SEEDS)) begin
        seed_count_r <= seed_count_r + 1'b1;
      end
      if (cmd.clr_start) begin
        clr_addr_r <= '0;
      end else if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      out_valid_r <= cmd.out_read | cmd.out_run;
    end
  end

  // sweep counters and working registers
  always_ff @(posedge clk) begin
    if (cmd.item_ld) item_r <= in_item;
    if (cmd.idx_init) begin
      seed_idx_r <= '0;
    end else if (cmd.plant) begin
      seed_idx_r <= seed_idx_r + 1'b1;
    end
    if (cmd.round_init) begin
      round_r <= agg_pkg::RW'(1);
      x_r     <= '0;
      y_r     <= '0;
    end
    if (cmd.round_next) round_r <= round_r + 1'b1;
    if (cmd.cell_next) begin
      if (int'(y_r) == agg_pkg::GRID_HEIGHT - 1) begin
        y_r <= '0;
        x_r <= (int'(x_r) == agg_pkg::GRID_WIDTH - 1) ? '0 : x_r + 1'b1;
      end else begin
        y_r <= y_r + 1'b1;
      end
    end
    if (cmd.me_ld) me_r <= cell_rd_r.owner;
    if (cmd.k_init) begin
      k_r <= 3'd0;
    end else if (cmd.k_next) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.nb_rd) begin
      nx_r <= agg_pkg::XW'(nxs);
      ny_r <= agg_pkg::YW'(nys);
    end
    if (cmd.t_oth_ld) t_oth_r <= arr_time;
    if (cmd.out_read) begin
      out_r.cell_label <= item_in_grid ? cell_rd_r.owner : 8'd0;
      out_r.run_done   <= 1'b0;
    end else if (cmd.out_run) begin
      out_r.cell_label <= 8'd0;
      out_r.run_done   <= 1'b1;
    end
  end

  // arrival time unit
  agg_arr u_arr (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.arr_start),
    .seed     (seed_rd_r),
    .nx       (nx_r),
    .ny       (ny_r),
    .done     (arr_done),
    .arr_time (arr_time)
  );

  // status to the controller
  always_comb begin
    st.clr_last    = (int'(clr_addr_r) == agg_pkg::CELLS - 1);
    st.seed_end    = (seed_idx_r == seed_count_r);
    st.rounds_zero = (max_rounds_r == '0);
    st.cell_claim  = (cell_rd_r.owner != '0) && (cell_rd_r.stamp < round_r);
    st.cell_last   = (int'(x_r) == agg_pkg::GRID_WIDTH - 1) &&
                     (int'(y_r) == agg_pkg::GRID_HEIGHT - 1);
    st.round_last  = (round_r == max_rounds_r);
    st.k_last      = (k_r == 3'd7);
    st.nb_in       = (nxs >= 0) && (nxs < (agg_pkg::XW+2)'(agg_pkg::GRID_WIDTH)) &&
                     (nys >= 0) && (nys < (agg_pkg::YW+2)'(agg_pkg::GRID_HEIGHT));
    st.nb_empty    = (cell_rd_r.owner == '0);
    st.nb_foreign  = (cell_rd_r.owner != me_r) && (cell_rd_r.stamp != '0);
    st.arr_done    = arr_done;
    st.arr_win     = (t_oth_r > arr_time);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

[sv/agg_ctrl.sv]
`default_nettype none
module agg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       mode,
  input  wire agg_pkg::status_t st,
  output agg_pkg::cmd_t         cmd,
  output logic                  busy
);

  typedef enum logic [17:0] {
    S_CLR      = 18'b000000000000000001,
    S_IDLE     = 18'b000000000000000010,
    S_PLANT_RD = 18'b000000000000000100,
    S_PLANT_WR = 18'b000000000000001000,
    S_CELL_RD  = 18'b000000000000010000,
    S_CELL_CHK = 18'b000000000000100000,
    S_NB_SEL   = 18'b000000000001000000,
    S_NB_CHK   = 18'b000000000010000000,
    S_OTH_RD   = 18'b000000000100000000,
    S_OTH_GO   = 18'b000000001000000000,
    S_OTH_WAIT = 18'b000000010000000000,
    S_ME_RD    = 18'b000000100000000000,
    S_ME_GO    = 18'b000001000000000000,
    S_ME_WAIT  = 18'b000010000000000000,
    S_CMP      = 18'b000100000000000000,
    S_READ_RD  = 18'b001000000000000000,
    S_READ_OUT = 18'b010000000000000000,
    S_DONE     = 18'b100000000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   running_r, running_nxt;
  logic   adv_k, adv_cell;

  always_comb begin
    state_nxt   = state_r;
    running_nxt = running_r;
    cmd         = '0;
    adv_k       = 1'b0;
    adv_cell    = 1'b0;
    case (state_r)
      // zero the grid, one cell a cycle
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = running_r ? S_PLANT_RD : S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.item_ld = 1'b1;
          case (mode)
            agg_pkg::MODE_CLEAR:  cmd.seed_clr = 1'b1;
            agg_pkg::MODE_APPEND: cmd.seed_app = 1'b1;
            agg_pkg::MODE_RUN: begin
              cmd.clr_start = 1'b1;
              cmd.idx_init  = 1'b1;
              running_nxt   = 1'b1;
              state_nxt     = S_CLR;
            end
            default: state_nxt = S_READ_RD;
          endcase
        end
      end
      // plant seeds in load order
      S_PLANT_RD: begin
        if (st.seed_end) begin
          cmd.round_init = 1'b1;
          state_nxt = st.rounds_zero ? S_DONE : S_CELL_RD;
        end else begin
          cmd.seed_rd  = 1'b1;
          cmd.seed_src = agg_pkg::SRC_PLANT;
          state_nxt    = S_PLANT_WR;
        end
      end
      S_PLANT_WR: begin
        cmd.plant = 1'b1;
        state_nxt = S_PLANT_RD;
      end
      // sweep
      S_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = S_CELL_CHK;
      end
      S_CELL_CHK: begin
        cmd.me_ld = 1'b1;
        if (st.cell_claim) begin
          cmd.k_init = 1'b1;
          state_nxt  = S_NB_SEL;
        end else begin
          adv_cell = 1'b1;
        end
      end
      S_NB_SEL: begin
        if (st.nb_in) begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NB_CHK;
        end else begin
          adv_k = 1'b1;
        end
      end
      S_NB_CHK: begin
        if (st.nb_empty) begin
          cmd.claim = 1'b1;
          adv_k     = 1'b1;
        end else if (st.nb_foreign) begin
          state_nxt = S_OTH_RD;
        end else begin
          adv_k = 1'b1;
        end
      end
      // arrival of the current owner, then of the challenger
      S_OTH_RD: begin
        cmd.seed_rd  = 1'b1;
        cmd.seed_src = agg_pkg::SRC_OTHER;
        state_nxt    = S_OTH_GO;
      end
      S_OTH_GO: begin
        cmd.arr_start = 1'b1;
        state_nxt     = S_OTH_WAIT;
      end
      S_OTH_WAIT: begin
        if (st.arr_done) begin
          cmd.t_oth_ld = 1'b1;
          state_nxt    = S_ME_RD;
        end
      end
      S_ME_RD: begin
        cmd.seed_rd  = 1'b1;
        cmd.seed_src = agg_pkg::SRC_ME;
        state_nxt    = S_ME_GO;
      end
      S_ME_GO: begin
        cmd.arr_start = 1'b1;
        state_nxt     = S_ME_WAIT;
      end
      S_ME_WAIT: begin
        if (st.arr_done) state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.claim = st.arr_win;
        adv_k     = 1'b1;
      end
      // label read
      S_READ_RD: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = S_READ_OUT;
      end
      S_READ_OUT: begin
        cmd.out_read = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DONE: begin
        cmd.out_run = 1'b1;
        running_nxt = 1'b0;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // step to the next neighbour or cell
    if (adv_k) begin
      if (st.k_last) begin
        adv_cell = 1'b1;
      end else begin
        cmd.k_next = 1'b1;
        state_nxt  = S_NB_SEL;
      end
    end
    if (adv_cell) begin
      cmd.cell_next = 1'b1;
      state_nxt     = S_CELL_RD;
      if (st.cell_last) begin
        if (st.round_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.round_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      running_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      running_r <= running_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

[sv/anisotropic_grain_growth.sv]
`default_nettype none
// Anisotropic grain growth engine on a 128 x 128 cell grid.
// Items enter on in_item when start is high and busy is low. Modes:
// clear the seed list, append a seed, run growth, read one cell label.
// Clear and append give no result; a read gives one result. A run
// clears the grid (all 16384 cells, one cell a cycle), plants the seeds,
// then sweeps max_rounds times over all cells; each cell is read and
// checked, each neighbour tried is read and checked, and for a contested
// neighbour the shared divider and square-root unit forms two arrival
// times. Its single result carries run_done set.
// max_rounds is written through cfg_we / cfg_wdata; the user must write
// it only while the block is idle, as the block does not enforce this.
// Results appear for one cycle with out_valid high; the receiver cannot
// stall and must take them then.
// After reset the grid is cleared first, so busy stays high until every
// cell is zeroed; max_rounds resets to 300 and the seed list to empty.
module anisotropic_grain_growth (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire agg_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output agg_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_wdata
);

  agg_pkg::cmd_t    cmd;
  agg_pkg::status_t st;

  agg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  agg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
